// ===== rtl/core/http_request_head_parser_defines.svh =====
// Assertion helpers shared by the parser RTL.
// Both expect a clock named clk and a synchronous active-high reset named rst.
`ifndef HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hrp_pkg.sv =====
`timescale 1ns / 1ps

package hrp_pkg;

  typedef enum logic [3:0] {
    PH_MSTART = 4'd0,
    PH_MP     = 4'd1,
    PH_MWORD  = 4'd2,
    PH_URL0   = 4'd3,
    PH_URL    = 4'd4,
    PH_VER0   = 4'd5,
    PH_VER    = 4'd6,
    PH_RLEND  = 4'd7,
    PH_HNAME0 = 4'd8,
    PH_HNAME  = 4'd9,
    PH_HDELIM = 4'd10,
    PH_HVAL0  = 4'd11,
    PH_HVAL   = 4'd12,
    PH_HLEND  = 4'd13,
    PH_HEND   = 4'd14,
    PH_DONE   = 4'd15
  } phase_t;

  localparam logic [2:0] ROLE_FRAMING = 3'd0;
  localparam logic [2:0] ROLE_METHOD  = 3'd1;
  localparam logic [2:0] ROLE_URL     = 3'd2;
  localparam logic [2:0] ROLE_VERSION = 3'd3;
  localparam logic [2:0] ROLE_NAME    = 3'd4;
  localparam logic [2:0] ROLE_VALUE   = 3'd5;

  localparam logic [2:0] METHOD_NONE    = 3'd0;
  localparam logic [2:0] METHOD_CONNECT = 3'd1;
  localparam logic [2:0] METHOD_GET     = 3'd2;
  localparam logic [2:0] METHOD_HEAD    = 3'd3;
  localparam logic [2:0] METHOD_POST    = 3'd4;
  localparam logic [2:0] METHOD_PUT     = 3'd5;

  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_ERROR = 2'd1;
  localparam logic [1:0] STATUS_OK    = 2'd2;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] match_idx;
    logic [2:0] found;
    logic       err;
  } parse_state_t;

  typedef struct packed {
    logic [2:0] role;
    logic [7:0] data;
    logic       first;
    logic       done;
    logic [2:0] method;
    logic [1:0] status;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:     PH_MSTART,
    match_idx: 3'd1,
    found:     METHOD_NONE,
    err:       1'b0
  };

endpackage

// ===== rtl/core/hrp_step.sv =====
`timescale 1ns / 1ps

module hrp_step (
  input  hrp_pkg::parse_state_t  state,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_request,
  output hrp_pkg::parse_state_t  state_next,
  output hrp_pkg::parse_result_t result
);
  import hrp_pkg::*;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_visible(input logic [7:0] c);
    return (c >= 8'h21) && (c <= 8'h7E);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    logic sep;
    sep = c inside {"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
                    "/", "[", "]", "?", "=", "{", "}"};
    return is_visible(c) && !sep;
  endfunction

  function automatic logic [2:0] word_len(input logic [2:0] m);
    case (m)
      METHOD_CONNECT: return 3'd7;
      METHOD_GET:     return 3'd3;
      METHOD_HEAD:    return 3'd4;
      METHOD_POST:    return 3'd4;
      METHOD_PUT:     return 3'd3;
      default:        return 3'd0;
    endcase
  endfunction

  // Lower-case letter expected at a given position of each method word.
  function automatic logic [7:0] word_char(input logic [2:0] m, input logic [2:0] idx);
    case ({m, idx})
      {METHOD_CONNECT, 3'd1}: return "o";
      {METHOD_CONNECT, 3'd2}: return "n";
      {METHOD_CONNECT, 3'd3}: return "n";
      {METHOD_CONNECT, 3'd4}: return "e";
      {METHOD_CONNECT, 3'd5}: return "c";
      {METHOD_CONNECT, 3'd6}: return "t";
      {METHOD_GET,     3'd1}: return "e";
      {METHOD_GET,     3'd2}: return "t";
      {METHOD_HEAD,    3'd1}: return "e";
      {METHOD_HEAD,    3'd2}: return "a";
      {METHOD_HEAD,    3'd3}: return "d";
      {METHOD_POST,    3'd1}: return "o";
      {METHOD_POST,    3'd2}: return "s";
      {METHOD_POST,    3'd3}: return "t";
      {METHOD_PUT,     3'd1}: return "u";
      {METHOD_PUT,     3'd2}: return "t";
      default:                return 8'h00;
    endcase
  endfunction

  parse_state_t upd;
  logic [7:0]   lc;
  logic         vis;
  logic         bad;
  logic [2:0]   role;
  logic [7:0]   ob;
  logic         first;
  logic         done;
  logic [1:0]   status;

  always_comb begin
    lc    = to_lower(data_byte);
    vis   = is_visible(data_byte);
    upd   = state;
    bad   = 1'b0;
    role  = ROLE_FRAMING;
    ob    = data_byte;
    first = 1'b0;
    done  = 1'b0;

    if (!state.err) begin
      case (state.phase)
        PH_MSTART: begin
          role = ROLE_METHOD;
          if (lc == "c") begin
            upd.found = METHOD_CONNECT;
            upd.phase = PH_MWORD;
          end else if (lc == "g") begin
            upd.found = METHOD_GET;
            upd.phase = PH_MWORD;
          end else if (lc == "h") begin
            upd.found = METHOD_HEAD;
            upd.phase = PH_MWORD;
          end else if (lc == "p") begin
            upd.phase = PH_MP;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MP: begin
          role = ROLE_METHOD;
          if (lc == "o" || lc == "u") begin
            upd.found     = (lc == "o") ? METHOD_POST : METHOD_PUT;
            upd.match_idx = 3'd2;
            upd.phase     = PH_MWORD;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MWORD: begin
          if (state.found == METHOD_NONE || state.found > METHOD_PUT) begin
            bad = 1'b1;
          end else if (state.match_idx < word_len(state.found)) begin
            if (lc != word_char(state.found, state.match_idx)) begin
              bad = 1'b1;
            end else begin
              upd.match_idx = state.match_idx + 3'd1;
              role          = ROLE_METHOD;
            end
          end else if (data_byte == CH_SP) begin
            done      = 1'b1;
            upd.phase = PH_URL0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_URL0: begin
          if (vis) begin
            role      = ROLE_URL;
            first     = 1'b1;
            upd.phase = PH_URL;
          end else begin
            bad = 1'b1;
          end
        end
        PH_VER0: begin
          if (vis) begin
            role      = ROLE_VERSION;
            first     = 1'b1;
            upd.phase = PH_VER;
          end else begin
            bad = 1'b1;
          end
        end
        PH_URL: begin
          if (vis) begin
            role = ROLE_URL;
          end else if (data_byte == CH_SP) begin
            done      = 1'b1;
            upd.phase = PH_VER0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_VER: begin
          if (vis) begin
            role = ROLE_VERSION;
          end else if (data_byte == CH_CR) begin
            done      = 1'b1;
            upd.phase = PH_RLEND;
          end else begin
            bad = 1'b1;
          end
        end
        PH_RLEND, PH_HLEND: begin
          if (data_byte == CH_LF) begin
            upd.phase = PH_HNAME0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HNAME0: begin
          if (data_byte == CH_CR) begin
            upd.phase = PH_HEND;
          end else if (is_name_char(data_byte)) begin
            role      = ROLE_NAME;
            ob        = lc;
            first     = 1'b1;
            upd.phase = PH_HNAME;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HNAME: begin
          if (is_name_char(data_byte)) begin
            role = ROLE_NAME;
            ob   = lc;
          end else if (data_byte == CH_COLON) begin
            done      = 1'b1;
            upd.phase = PH_HDELIM;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HDELIM: begin
          if (data_byte == CH_SP) begin
            upd.phase = PH_HVAL0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HVAL0: begin
          if (vis) begin
            role      = ROLE_VALUE;
            first     = 1'b1;
            upd.phase = PH_HVAL;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HVAL: begin
          if (vis || data_byte == CH_SP) begin
            role = ROLE_VALUE;
          end else if (data_byte == CH_CR) begin
            done      = 1'b1;
            upd.phase = PH_HLEND;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HEND: begin
          if (data_byte == CH_LF) begin
            upd.phase = PH_DONE;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DONE: begin
          // Trailing bytes after the blank line are passed through untouched.
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end

    upd.err = state.err | bad;
    if (upd.err) begin
      role  = ROLE_FRAMING;
      ob    = data_byte;
      first = 1'b0;
      done  = 1'b0;
    end

    if (end_of_request) begin
      status = (!upd.err && upd.phase == PH_DONE) ? STATUS_OK : STATUS_ERROR;
    end else begin
      status = upd.err ? STATUS_ERROR : STATUS_BUSY;
    end

    result.role   = role;
    result.data   = ob;
    result.first  = first;
    result.done   = done;
    result.method = upd.found;
    result.status = status;

    // The last byte of a request rearms the parser for the next one.
    state_next = end_of_request ? STATE_RESET : upd;
  end

endmodule

// ===== rtl/core/http_request_head_parser.sv =====
// Channel   Handshake                    Payload
// input     byte_valid / byte_ready      data_byte, end_of_request
// result    result_valid / result_ready  byte_role, out_byte, token_first, token_done,
//                                        method_code, parse_status
//
// One byte is taken per cycle; each result appears the cycle after its byte is taken.
// The rate is set by the parse state register, which is updated from each accepted beat
// through one pass of classification logic.
// The result register holds a beat until it is taken; a new byte is accepted in the same
// cycle as the waiting result leaves, so a stall on the result side stalls the input.
// Synchronous reset returns the parser to the start of a request with no result pending.
`timescale 1ns / 1ps
`include "http_request_head_parser_defines.svh"

module http_request_head_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_request,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [2:0] byte_role,
  output logic [7:0] out_byte,
  output logic       token_first,
  output logic       token_done,
  output logic [2:0] method_code,
  output logic [1:0] parse_status
);
  import hrp_pkg::*;

  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_result;
  logic          accept;
  logic          last_accept;
  logic          done_beat;

  assign byte_ready  = !result_valid || result_ready;
  assign accept      = byte_valid && byte_ready;
  assign last_accept = accept && end_of_request;
  assign done_beat   = result_valid && token_done;

  hrp_step u_step (
    .state          (state),
    .data_byte      (data_byte),
    .end_of_request (end_of_request),
    .state_next     (state_next),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= STATE_RESET;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        state        <= state_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_role    <= step_result.role;
      out_byte     <= step_result.data;
      token_first  <= step_result.first;
      token_done   <= step_result.done;
      method_code  <= step_result.method;
      parse_status <= step_result.status;
    end
  end

  `HRP_ASSERT_SAME(a_marks_exclusive, result_valid, !(token_first && token_done), "marks clash")
  `HRP_ASSERT_SAME(a_done_is_framing, done_beat, byte_role == ROLE_FRAMING, "end mark with role")
  `HRP_ASSERT_NEXT(a_rearm_on_last, last_accept, state == STATE_RESET, "parser not rearmed")
  `HRP_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result dropped")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hrp_pkg::*;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_request = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [2:0] byte_role;
  logic [7:0] out_byte;
  logic       token_first;
  logic       token_done;
  logic [2:0] method_code;
  logic [1:0] parse_status;

  // Parser state as the checker believes it to be.
  phase_t     cur_phase;
  logic [2:0] match_pos;
  logic [2:0] method_seen;
  logic       error_latched;

  parse_result_t expected_results[$];
  logic [7:0]    req_text[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int requests_sent = 0;
  int heads_completed = 0;
  int heads_failed = 0;

  http_request_head_parser i_dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .data_byte      (data_byte),
    .end_of_request (end_of_request),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .byte_role      (byte_role),
    .out_byte       (out_byte),
    .token_first    (token_first),
    .token_done     (token_done),
    .method_code    (method_code),
    .parse_status   (parse_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] to_lower_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_visible(input logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E;
  endfunction

  function automatic logic is_token_char(input logic [7:0] c);
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}": return 1'b0;
      default: return is_visible(c);
    endcase
  endfunction

  function automatic string method_word(input logic [2:0] m);
    case (m)
      METHOD_CONNECT: return "connect";
      METHOD_GET:     return "get";
      METHOD_HEAD:    return "head";
      METHOD_POST:    return "post";
      METHOD_PUT:     return "put";
      default:        return "";
    endcase
  endfunction

  function automatic void rearm_parser_model();
    cur_phase     = PH_MSTART;
    match_pos     = 3'd1;
    method_seen   = METHOD_NONE;
    error_latched = 1'b0;
  endfunction

  // Works out the result beat for one byte and advances the parser state.
  function automatic parse_result_t predict_byte(input logic [7:0] c, input logic last);
    logic [7:0]    lc;
    logic          bad;
    string         word;
    parse_result_t r;
    lc      = to_lower_case(c);
    bad     = 1'b0;
    r.role  = ROLE_FRAMING;
    r.data  = c;
    r.first = 1'b0;
    r.done  = 1'b0;
    if (!error_latched) begin
      case (cur_phase)
        PH_MSTART: begin
          r.role = ROLE_METHOD;
          if (lc == "c") begin
            method_seen = METHOD_CONNECT;
            cur_phase = PH_MWORD;
          end else if (lc == "g") begin
            method_seen = METHOD_GET;
            cur_phase = PH_MWORD;
          end else if (lc == "h") begin
            method_seen = METHOD_HEAD;
            cur_phase = PH_MWORD;
          end else if (lc == "p") begin
            cur_phase = PH_MP;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MP: begin
          r.role = ROLE_METHOD;
          if (lc == "o") method_seen = METHOD_POST;
          else if (lc == "u") method_seen = METHOD_PUT;
          else bad = 1'b1;
          if (!bad) begin
            match_pos = 3'd2;
            cur_phase = PH_MWORD;
          end
        end
        PH_MWORD: begin
          word = method_word(method_seen);
          if (word.len() == 0) begin
            bad = 1'b1;
          end else if (match_pos < word.len()) begin
            if (lc != word[match_pos]) begin
              bad = 1'b1;
            end else begin
              match_pos = match_pos + 3'd1;
              r.role = ROLE_METHOD;
            end
          end else if (c == CH_SP) begin
            r.done = 1'b1;
            cur_phase = PH_URL0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_URL0, PH_VER0: begin
          if (is_visible(c)) begin
            r.role = (cur_phase == PH_URL0) ? ROLE_URL : ROLE_VERSION;
            r.first = 1'b1;
            cur_phase = (cur_phase == PH_URL0) ? PH_URL : PH_VER;
          end else begin
            bad = 1'b1;
          end
        end
        PH_URL: begin
          if (is_visible(c)) begin
            r.role = ROLE_URL;
          end else if (c == CH_SP) begin
            r.done = 1'b1;
            cur_phase = PH_VER0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_VER: begin
          if (is_visible(c)) begin
            r.role = ROLE_VERSION;
          end else if (c == CH_CR) begin
            r.done = 1'b1;
            cur_phase = PH_RLEND;
          end else begin
            bad = 1'b1;
          end
        end
        PH_RLEND, PH_HLEND: begin
          if (c == CH_LF) cur_phase = PH_HNAME0;
          else bad = 1'b1;
        end
        PH_HNAME0: begin
          if (c == CH_CR) begin
            cur_phase = PH_HEND;
          end else if (is_token_char(c)) begin
            r.role = ROLE_NAME;
            r.data = lc;
            r.first = 1'b1;
            cur_phase = PH_HNAME;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HNAME: begin
          if (is_token_char(c)) begin
            r.role = ROLE_NAME;
            r.data = lc;
          end else if (c == CH_COLON) begin
            r.done = 1'b1;
            cur_phase = PH_HDELIM;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HDELIM: begin
          if (c == CH_SP) cur_phase = PH_HVAL0;
          else bad = 1'b1;
        end
        PH_HVAL0: begin
          if (is_visible(c)) begin
            r.role = ROLE_VALUE;
            r.first = 1'b1;
            cur_phase = PH_HVAL;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HVAL: begin
          if (is_visible(c) || c == CH_SP) begin
            r.role = ROLE_VALUE;
          end else if (c == CH_CR) begin
            r.done = 1'b1;
            cur_phase = PH_HLEND;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HEND: begin
          if (c == CH_LF) cur_phase = PH_DONE;
          else bad = 1'b1;
        end
        PH_DONE: begin
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) error_latched = 1'b1;
    if (error_latched) begin
      r.role  = ROLE_FRAMING;
      r.data  = c;
      r.first = 1'b0;
      r.done  = 1'b0;
    end
    r.method = method_seen;
    r.status = error_latched ? STATUS_ERROR : STATUS_BUSY;
    if (last) begin
      r.status = (!error_latched && cur_phase == PH_DONE) ? STATUS_OK : STATUS_ERROR;
      rearm_parser_model();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("MISMATCH at result %0d: %s got %0h expected %0h",
             results_checked, what, got, want);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    parse_result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid     <= 1'b1;
    data_byte      <= b;
    end_of_request <= last;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    want = predict_byte(b, last);
    expected_results.push_back(want);
    bytes_sent++;
    if (last && want.status == STATUS_OK) heads_completed++;
    if (last && want.status == STATUS_ERROR) heads_failed++;
    @(negedge clk);
  endtask

  task automatic send_request();
    for (int i = 0; i < req_text.size(); i++) begin
      send_byte(req_text[i], i == req_text.size() - 1);
    end
    requests_sent++;
  endtask

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) req_text.push_back(s[i]);
  endfunction

  function automatic void append_crlf();
    req_text.push_back(CH_CR);
    req_text.push_back(CH_LF);
  endfunction

  function automatic logic [7:0] random_visible();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [7:0] random_token_char();
    logic [7:0] c;
    c = random_visible();
    while (!is_token_char(c)) c = random_visible();
    return c;
  endfunction

  // A well-formed head with random content, mixed case and sometimes trailing bytes.
  function automatic void build_request();
    string      word;
    logic [7:0] c;
    req_text.delete();
    word = method_word(3'($urandom_range(METHOD_CONNECT, METHOD_PUT)));
    for (int i = 0; i < word.len(); i++) begin
      c = word[i];
      if ($urandom_range(0, 1)) c = c - 8'd32;
      req_text.push_back(c);
    end
    req_text.push_back(CH_SP);
    repeat ($urandom_range(1, 6)) req_text.push_back(random_visible());
    req_text.push_back(CH_SP);
    repeat ($urandom_range(1, 8)) req_text.push_back(random_visible());
    append_crlf();
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 6)) req_text.push_back(random_token_char());
      req_text.push_back(CH_COLON);
      req_text.push_back(CH_SP);
      req_text.push_back(random_visible());
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 3) == 0) req_text.push_back(CH_SP);
        else req_text.push_back(random_visible());
      end
      append_crlf();
    end
    append_crlf();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) req_text.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Either a byte overwritten with any value or the request cut short.
  function automatic void break_request();
    int keep;
    if ($urandom_range(0, 1)) begin
      req_text[$urandom_range(0, req_text.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      keep = $urandom_range(1, req_text.size() - 1);
      while (req_text.size() > keep) void'(req_text.pop_back());
    end
  endfunction

  task automatic test_directed_request();
    // POST in mixed case, visible extremes, an upper-case name and a value with a space.
    req_text.delete();
    append_text("pOsT ~ !");
    append_crlf();
    append_text("Z!: ~ ");
    append_crlf();
    append_crlf();
    send_request();
  endtask

  task automatic test_single_byte_requests();
    logic [7:0] lone[3];
    lone = '{8'hFF, 8'h00, "G"};
    foreach (lone[i]) begin
      req_text.delete();
      req_text.push_back(lone[i]);
      send_request();
    end
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int n_bytes);
    int start_count;
    int kind;
    send_idle_pct  = sender_idle;
    recv_stall_pct = receiver_stall;
    start_count    = bytes_sent;
    while (bytes_sent - start_count < n_bytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        req_text.delete();
        repeat ($urandom_range(1, 4)) req_text.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_request();
        if (kind < 30) break_request();
      end
      send_request();
    end
  endtask

  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", int'(out_byte), 0);
      end else begin
        want = expected_results.pop_front();
        if (byte_role !== want.role)
          report_mismatch("byte_role", int'(byte_role), int'(want.role));
        if (out_byte !== want.data)
          report_mismatch("out_byte", int'(out_byte), int'(want.data));
        if (token_first !== want.first)
          report_mismatch("token_first", int'(token_first), int'(want.first));
        if (token_done !== want.done)
          report_mismatch("token_done", int'(token_done), int'(want.done));
        if (method_code !== want.method)
          report_mismatch("method_code", int'(method_code), int'(want.method));
        if (parse_status !== want.status)
          report_mismatch("parse_status", int'(parse_status), int'(want.status));
        results_checked++;
      end
    end
  end

  initial begin
    int waited;
    rearm_parser_model();
    send_idle_pct  = 27;
    recv_stall_pct = 81;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_request();
    test_single_byte_requests();
    test_random_traffic(27, 81, 560);
    test_random_traffic(81, 27, 560);
    test_random_traffic(0, 0, 560);
    byte_valid <= 1'b0;

    waited = 0;
    while (expected_results.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("result beats never delivered", 0, expected_results.size());
    end

    $display("Checked %0d result beats for %0d bytes in %0d requests.",
             results_checked, bytes_sent, requests_sent);
    $display("%0d heads completed cleanly, %0d requests ended in error; %0d mismatches.",
             heads_completed, heads_failed, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hrp_pkg.sv
rtl/core/hrp_step.sv
rtl/core/http_request_head_parser.sv
sim/tb_top.sv
